>>> hdl/haplotype_segment_transition_counter_core_defines.svh
// Assertion macros used by the checker file of the segment transition counter.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef HAPLOTYPE_SEGMENT_TRANSITION_COUNTER_CORE_DEFINES_SVH
`define HAPLOTYPE_SEGMENT_TRANSITION_COUNTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define HSTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HSTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hstc_pkg.sv
// Shared types and constants of the haplotype segment transition counter.
// No dependencies.
package hstc_pkg;
    localparam int BIN_W      = 6;
    localparam int CNT_W      = 13;
    localparam int NUM_BINS   = 64;
    localparam int FIRST_BINS = 8;
    localparam logic [1:0] GT_HET       = 2'd1;
    localparam logic [1:0] HETS_PER_SEG = 2'd3;
    localparam logic [3:0] PAT_INVALID  = 4'd8;

    typedef struct packed {
        logic [3:0] prev;
        logic [2:0] cur;
        logic       cons;
    } t_hap_entry;
endpackage

>>> hdl/hstc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module hstc_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

>>> hdl/haplotype_segment_transition_counter_core.sv
// Haplotype segment transition counter, top level.
// Depends on hstc_pkg and hstc_ram.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one word per haplotype allele:
//   genotype, hap_index, allele, site_done and input_done.
//   Output channel (o_valid / i_stall) carries one word per table bin:
//   bin_index, bin_count, first_table, partial_hets, table_last.
// Throughput: one input word per cycle while the input is not stalled. A
//   word that closes a segment (or ends the input with open het sites)
//   stalls the input while the read-modify-write pipe drains and the table
//   is flushed, each bin read from the registered bin count memory in S_RD
//   and sent from S_WT (8 bins for the first table, 64 otherwise), plus any
//   output stall. A word that ends the input with no open het sites stalls
//   the input while the pipe drains and the counts are dropped.
// The first bin word follows the closing word through S_DRAIN, S_RD and S_WT.
// Per-haplotype state sits in a HAPLOTYPES-deep memory (read, modify, write
//   back in the next cycle, with one-deep forwarding); bin counts sit in a
//   64-entry memory with valid bits that reset and each flush clear at once.
// Reset: synchronous, active low; returns to the start of a first segment.
//   The haplotype memory is not cleared.
// Output stall: the bin word holds in the output register; the flush waits.
module haplotype_segment_transition_counter_core #(
    parameter int HAPLOTYPES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_genotype,
    input  logic [11:0] i_hap_index,
    input  logic        i_allele,
    input  logic        i_site_done,
    input  logic        i_input_done,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_bin_index,
    output logic [12:0] o_bin_count,
    output logic        o_first_table,
    output logic [1:0]  o_partial_hets,
    output logic        o_table_last
);
    localparam int AW = $clog2(HAPLOTYPES);
    localparam int XW = (AW > 12) ? AW : 12;
    localparam int EW = $bits(hstc_pkg::t_hap_entry);
    localparam int BW = hstc_pkg::BIN_W;
    localparam int CW = hstc_pkg::CNT_W;

    typedef enum logic [1:0] {S_RUN, S_DRAIN, S_RD, S_WT} t_state;

    // control state
    t_state      r_state;
    logic [1:0]  r_hets;
    logic        r_seg_start;
    logic        r_in_first;

    // stage 1: haplotype read-modify-write
    logic          r_s1_v;
    logic [AW-1:0] r_s1_addr;
    logic          r_s1_seg_start, r_s1_het, r_s1_cnt, r_s1_first, r_s1_a;
    logic [1:0]    r_s1_g;
    logic          r_fw_v;
    logic [AW-1:0] r_fw_addr;
    hstc_pkg::t_hap_entry r_fw_data;

    // stage 2: bin bump
    logic          r_s2_v;
    logic [BW-1:0] r_s2_bin;
    logic          r_bw_v;
    logic [BW-1:0] r_bw_bin;
    logic [CW-1:0] r_bw_val;
    logic [hstc_pkg::NUM_BINS-1:0] r_bvalid;

    // flush
    logic [BW-1:0] r_idx;
    logic          r_em_first;
    logic [1:0]    r_em_hets;
    logic          r_em_clr;

    logic          accept;
    logic [XW-1:0] hap_x;
    logic          hap_ok;
    logic          in_het;
    logic [2:0]    eff;
    logic          eff_full, in_cnt, in_emit;

    logic [EW-1:0] hap_q;
    hstc_pkg::t_hap_entry s1_d, s1_n;
    logic          s1_bump;
    logic [BW-1:0] s1_bin;

    logic [CW-1:0] bin_q;
    logic [CW-1:0] s2_old, s2_new;
    logic [BW-1:0] bin_raddr;
    logic          bin_we;
    logic [BW-1:0] bin_waddr;
    logic [BW-1:0] last_idx;
    logic          out_free;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_RUN);
    assign hap_x    = XW'(i_hap_index);
    assign hap_ok   = (32'(i_hap_index) < HAPLOTYPES);
    assign in_het   = (i_genotype == hstc_pkg::GT_HET);
    assign eff      = {1'b0, r_hets} + {2'b00, in_het};
    assign eff_full = (eff >= 3'(hstc_pkg::HETS_PER_SEG));
    assign in_cnt   = eff_full || (i_input_done && (eff != 3'd0));
    assign in_emit  = i_site_done && in_cnt;

    hstc_ram #(.W(EW), .D(HAPLOTYPES)) u_hap_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_n),
        .i_raddr (hap_x[AW-1:0]),
        .o_rdata (hap_q)
    );

    // stage 1: forward the entry written last cycle, then update
    always_comb begin
        s1_d = (r_fw_v && (r_fw_addr == r_s1_addr)) ? r_fw_data
                                                     : hstc_pkg::t_hap_entry'(hap_q);
        s1_n    = s1_d;
        s1_bump = 1'b0;
        s1_bin  = '0;
        if (r_s1_seg_start) begin
            s1_n.cons = 1'b1;
            s1_n.cur  = 3'd0;
        end
        if (s1_n.cons) begin
            if (r_s1_het) begin
                s1_n.cur = {s1_n.cur[1:0], r_s1_a};
            end else if (r_s1_a != r_s1_g[1]) begin
                s1_n.cons = 1'b0;
            end
        end
        if (r_s1_cnt) begin
            if (s1_n.cons) begin
                if (r_s1_first) begin
                    s1_bump = 1'b1;
                    s1_bin  = BW'(s1_n.cur);
                end else if (s1_n.prev < hstc_pkg::PAT_INVALID) begin
                    s1_bump = 1'b1;
                    s1_bin  = {s1_n.prev[2:0], s1_n.cur};
                end
                s1_n.prev = {1'b0, s1_n.cur};
            end else begin
                s1_n.prev = hstc_pkg::PAT_INVALID;
            end
        end
    end

    // stage 2: saturating bump with one-deep forwarding
    assign bin_raddr = ((r_state == S_RD) || (r_state == S_WT)) ? r_idx : s1_bin;
    assign s2_old    = (r_bw_v && (r_bw_bin == r_s2_bin)) ? r_bw_val
                     : (r_bvalid[r_s2_bin] ? bin_q : '0);
    assign s2_new    = (s2_old == {CW{1'b1}}) ? s2_old : s2_old + CW'(1);
    assign bin_we    = r_s2_v;
    assign bin_waddr = r_s2_bin;

    hstc_ram #(.W(CW), .D(hstc_pkg::NUM_BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (s2_new),
        .i_raddr (bin_raddr),
        .o_rdata (bin_q)
    );

    assign last_idx = r_em_first ? BW'(hstc_pkg::FIRST_BINS - 1)
                                 : BW'(hstc_pkg::NUM_BINS - 1);
    assign out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_hets      <= 2'd0;
            r_seg_start <= 1'b1;
            r_in_first  <= 1'b1;
            r_s1_v      <= 1'b0;
            r_fw_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_bw_v      <= 1'b0;
            r_bvalid    <= '0;
            o_valid     <= 1'b0;
        end else begin
            // stage 1 capture
            r_s1_v <= accept && hap_ok;
            if (accept) begin
                r_s1_addr      <= hap_x[AW-1:0];
                r_s1_seg_start <= r_seg_start;
                r_s1_het       <= in_het;
                r_s1_cnt       <= in_cnt;
                r_s1_first     <= r_in_first;
                r_s1_a         <= i_allele;
                r_s1_g         <= i_genotype;
            end
            // segment control advances on the word that closes a site
            if (accept && i_site_done) begin
                r_seg_start <= 1'b0;
                if (eff_full) begin
                    r_hets      <= 2'd0;
                    r_seg_start <= 1'b1;
                    r_in_first  <= i_input_done;
                end else if (i_input_done) begin
                    r_hets      <= 2'd0;
                    r_seg_start <= 1'b1;
                    r_in_first  <= 1'b1;
                end else begin
                    r_hets <= eff[1:0];
                end
            end
            r_fw_v    <= r_s1_v;
            r_fw_addr <= r_s1_addr;
            r_fw_data <= s1_n;
            // stage 2 capture
            r_s2_v   <= r_s1_v && s1_bump;
            r_s2_bin <= s1_bin;
            r_bw_v   <= r_s2_v;
            r_bw_bin <= r_s2_bin;
            r_bw_val <= s2_new;
            if (r_s2_v) begin
                r_bvalid[r_s2_bin] <= 1'b1;
            end
            // drop the word once taken; the flush loads the next one itself
            if (o_valid && !i_stall && (r_state != S_WT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_RUN: begin
                    if (accept && in_emit) begin
                        r_state    <= S_DRAIN;
                        r_em_first <= r_in_first;
                        r_em_hets  <= eff_full ? hstc_pkg::HETS_PER_SEG : eff[1:0];
                        r_em_clr   <= 1'b0;
                        r_idx      <= '0;
                    end else if (accept && i_site_done && i_input_done) begin
                        // end of input with no open hets: drop the counts only
                        r_state  <= S_DRAIN;
                        r_em_clr <= 1'b1;
                    end
                end
                S_DRAIN: begin
                    // wait for the closing word to finish its bump
                    if (!r_s1_v && !r_s2_v) begin
                        if (r_em_clr) begin
                            r_bvalid <= '0;
                            r_state  <= S_RUN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WT;
                end
                S_WT: begin
                    if (out_free) begin
                        o_valid        <= 1'b1;
                        o_bin_index    <= r_idx;
                        o_bin_count    <= r_bvalid[r_idx] ? bin_q : '0;
                        o_first_table  <= r_em_first;
                        o_partial_hets <= r_em_hets;
                        o_table_last   <= (r_idx == last_idx);
                        if (r_idx == last_idx) begin
                            r_bvalid <= '0;
                            r_state  <= S_RUN;
                        end else begin
                            r_idx   <= r_idx + BW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_RUN;
            endcase
        end
    end
endmodule

>>> hdl/hstc_checker.sv
// Port-level checker for the haplotype segment transition counter, with its bind.
// Depends on hstc_pkg and the assertion macro header.
`include "haplotype_segment_transition_counter_core_defines.svh"

module hstc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [5:0]  o_bin_index,
    input logic        o_first_table,
    input logic [1:0]  o_partial_hets,
    input logic        o_table_last
);
    logic stalled;
    logic first_ok;
    logic first_end;
    logic wide_end;

    assign stalled   = o_valid && i_stall;
    assign first_ok  = (o_bin_index < 6'(hstc_pkg::FIRST_BINS));
    assign first_end = o_first_table && (o_bin_index == 6'(hstc_pkg::FIRST_BINS - 1));
    assign wide_end  = !o_first_table && (o_bin_index == 6'(hstc_pkg::NUM_BINS - 1));

    `HSTC_ASSERT_NXT(a_out_hold, stalled, o_valid && $stable(o_bin_index), "stalled word lost")
    `HSTC_ASSERT_IMP(a_first_range, o_valid && o_first_table, first_ok, "first bin out of range")
    `HSTC_ASSERT_IMP(a_last_bin, o_valid && o_table_last, first_end || wide_end, "bad table end")
    `HSTC_ASSERT_IMP(a_hets_nonzero, o_valid, o_partial_hets != 2'd0, "table with no het sites")
endmodule

bind haplotype_segment_transition_counter_core hstc_checker u_hstc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_bin_index    (o_bin_index),
    .o_first_table  (o_first_table),
    .o_partial_hets (o_partial_hets),
    .o_table_last   (o_table_last)
);
